@@ rtl/core/hprs_pkg.sv @@
package hprs_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W     = (IDX_W > 4) ? IDX_W : 4;

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_SCHED = 1'b1;

  localparam logic [1:0] ST_DORMANT = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  typedef struct packed {
    logic             tok;
    logic             have;
    logic [7:0]       prio;
    logic [IDX_W-1:0] slot;
    logic [15:0]      id;
  } cand_t;

  typedef struct packed {
    logic             load_en;
    logic [3:0]       load_slot;
    logic             load_valid;
    logic [1:0]       load_state;
    logic [7:0]       load_prio;
    logic             load_excl;
    logic [15:0]      load_id;
    logic             demote_en;
    logic [IDX_W-1:0] demote_slot;
    logic             run_en;
    logic [IDX_W-1:0] run_slot;
  } ctl_t;

endpackage

@@ rtl/core/hprs_if.sv @@
interface hprs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  slot;
  logic        entry_valid_in;
  logic [1:0]  entry_state_in;
  logic [7:0]  entry_priority_in;
  logic        entry_excluded_in;
  logic [15:0] entry_id_in;

  modport source (
    output valid, cmd, slot, entry_valid_in, entry_state_in, entry_priority_in,
           entry_excluded_in, entry_id_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, entry_valid_in, entry_state_in, entry_priority_in,
           entry_excluded_in, entry_id_in,
    output ready
  );
endinterface

interface hprs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] chosen_id;
  logic [3:0]  chosen_slot;

  modport source (
    output valid, found, chosen_id, chosen_slot,
    input  ready
  );
  modport sink (
    input  valid, found, chosen_id, chosen_slot,
    output ready
  );
endinterface

@@ rtl/core/highest_priority_ready_selector.sv @@
// Fixed-priority scheduler core over a row of NUM_SLOTS slot cells. A load
// transfer writes one slot and gives no result; loads to an index outside
// the table are dropped. A schedule transfer demotes the current running
// slot to ready, then a scan token walks the cell row one slot per cycle,
// carrying the best ready, non-excluded candidate so far (highest priority,
// lowest slot on a tie). The token passes through start_r, each cell and
// the pending register, where the result waits until the output register
// is free. Input ready stays low from the schedule transfer until the
// result is placed in the output register. With no candidate the result
// is found 0, id 0, slot 0 and the current process is cleared.
module highest_priority_ready_selector (
  input  logic      clk,
  input  logic      rst_n,
  hprs_in_if.sink   in_ch,
  hprs_out_if.source out_ch
);

  localparam int N = hprs_pkg::NUM_SLOTS;

  hprs_pkg::cand_t chain [N+1];
  hprs_pkg::ctl_t  ctl;

  logic                      busy_r, busy_nxt;
  logic                      start_r;
  logic                      pend_r, pend_nxt;
  logic                      pend_have_r;
  logic [hprs_pkg::IDX_W-1:0] pend_slot_r;
  logic [15:0]               pend_id_r;
  logic                      cur_valid_r;
  logic [hprs_pkg::IDX_W-1:0] cur_slot_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r;
  logic [15:0]               out_id_r;
  logic [3:0]                out_slot_r;
  logic                      in_fire;
  logic                      sched_fire;
  logic                      move;

  assign in_ch.ready = !busy_r;
  assign in_fire     = in_ch.valid && !busy_r;
  assign sched_fire  = in_fire && in_ch.cmd == hprs_pkg::CMD_SCHED;
  assign move        = pend_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.load_en     = in_fire && in_ch.cmd == hprs_pkg::CMD_LOAD;
    ctl.load_slot   = in_ch.slot;
    ctl.load_valid  = in_ch.entry_valid_in;
    ctl.load_state  = in_ch.entry_state_in;
    ctl.load_prio   = in_ch.entry_priority_in;
    ctl.load_excl   = in_ch.entry_excluded_in;
    ctl.load_id     = in_ch.entry_id_in;
    ctl.demote_en   = sched_fire && cur_valid_r;
    ctl.demote_slot = cur_slot_r;
    ctl.run_en      = move && pend_have_r;
    ctl.run_slot    = pend_slot_r;
  end

  assign chain[0] = '{tok: start_r, default: '0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    hprs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (hprs_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    if (sched_fire) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
    pend_nxt = pend_r;
    if (chain[N].tok) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= sched_fire;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (move) begin
        cur_valid_r <= pend_have_r;
        cur_slot_r  <= pend_have_r ? pend_slot_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain[N].tok) begin
      pend_have_r <= chain[N].have;
      pend_slot_r <= chain[N].slot;
      pend_id_r   <= chain[N].id;
    end
    if (move) begin
      out_found_r <= pend_have_r;
      out_id_r    <= pend_have_r ? pend_id_r : 16'd0;
      out_slot_r  <= pend_have_r ? 4'(pend_slot_r) : 4'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.chosen_id   = out_id_r;
  assign out_ch.chosen_slot = out_slot_r;

  logic [N:0] tok_vec;
  always_comb begin
    for (int k = 0; k <= N; k++) begin
      tok_vec[k] = chain[k].tok;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vec, pend_r}))
    else $error("more than one scan in flight");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || chain[N].tok || pend_r) |-> busy_r)
    else $error("scan active while input ready");

  a_current: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (cur_valid_r == out_found_r && out_valid_r))
    else $error("current process does not match delivered result");

endmodule

@@ rtl/core/hprs_cell.sv @@
module hprs_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hprs_pkg::IDX_W-1:0] my_idx,
  input  hprs_pkg::ctl_t            ctl,
  input  hprs_pkg::cand_t           cand_in,
  output hprs_pkg::cand_t           cand_out
);

  logic        valid_r;
  logic [1:0]  state_r;
  logic [7:0]  prio_r;
  logic        excl_r;
  logic [15:0] id_r;
  logic [1:0]  state_nxt;
  logic        load_hit;
  logic        take;
  hprs_pkg::cand_t cand_r;
  hprs_pkg::cand_t cand_nxt;

  assign load_hit = ctl.load_en &&
                    (hprs_pkg::CMP_W'(ctl.load_slot) == hprs_pkg::CMP_W'(my_idx));

  always_comb begin
    state_nxt = state_r;
    if (load_hit) begin
      state_nxt = ctl.load_state;
    end else if (ctl.run_en && ctl.run_slot == my_idx) begin
      state_nxt = hprs_pkg::ST_RUNNING;
    end else if (ctl.demote_en && ctl.demote_slot == my_idx &&
                 state_r == hprs_pkg::ST_RUNNING) begin
      state_nxt = hprs_pkg::ST_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      state_r <= hprs_pkg::ST_DORMANT;
      prio_r  <= 8'd0;
      excl_r  <= 1'b0;
      id_r    <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (load_hit) begin
        valid_r <= ctl.load_valid;
        prio_r  <= ctl.load_prio;
        excl_r  <= ctl.load_excl;
        id_r    <= ctl.load_id;
      end
    end
  end

  // strict greater-than keeps the lowest slot on a tie
  assign take = valid_r && state_r == hprs_pkg::ST_READY && !excl_r &&
                (!cand_in.have || prio_r > cand_in.prio);

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.have = 1'b1;
      cand_nxt.prio = prio_r;
      cand_nxt.slot = my_idx;
      cand_nxt.id   = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.tok <= 1'b0;
    end else begin
      cand_r.tok <= cand_in.tok;
    end
    cand_r.have <= cand_nxt.have;
    cand_r.prio <= cand_nxt.prio;
    cand_r.slot <= cand_nxt.slot;
    cand_r.id   <= cand_nxt.id;
  end

  assign cand_out = cand_r;

endmodule
